/* src/pulse_actuator_sequencer_macros.svh */
// ----------------------------------------------------------------------------
// pulse_actuator_sequencer_macros.svh
// Assertion macros for the pulse actuator sequencer.
// ----------------------------------------------------------------------------
`ifndef PULSE_ACTUATOR_SEQUENCER_MACROS_SVH
`define PULSE_ACTUATOR_SEQUENCER_MACROS_SVH

`ifndef SYNTH
`define PAS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PAS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PAS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PAS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

/* src/pas_pkg.sv */
// ----------------------------------------------------------------------------
// pas_pkg
// Types, codes and constants shared by the pulse actuator sequencer.
// ----------------------------------------------------------------------------
package pas_pkg;

	localparam int TIME_WIDTH = 16;
	localparam int CFG_W      = 16;
	localparam int VEL_W      = 7;
	localparam int PROD_W     = CFG_W + VEL_W;
	localparam int IDX_W      = 8;
	localparam int CMP_W      = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
	localparam int VEL_FULL   = 127;

	localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_DOWN_TIME   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_UP_TIME     = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_MIN_UP_TIME = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_PWM_MAX     = IDX_W'(3);

	localparam logic [CFG_W-1:0] RST_DOWN_TIME   = CFG_W'(50);
	localparam logic [CFG_W-1:0] RST_UP_TIME     = CFG_W'(100);
	localparam logic [CFG_W-1:0] RST_MIN_UP_TIME = CFG_W'(30);
	localparam logic [CFG_W-1:0] RST_PWM_MAX     = CFG_W'(1000);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DOWN = 2'd1,
		PH_UP   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_VEL   = 2'd1,
		CMD_FAULT = 2'd2,
		CMD_INIT  = 2'd3
	} cmd_t;

	// floor(p / 127) for a velocity * pwm_max product, without a divider
	function automatic logic [CFG_W-1:0] div_full_scale(input logic [PROD_W-1:0] p);
		logic [CFG_W:0]    q_est;
		logic [PROD_W:0]   rem_w;
		logic [9:0]        rem;
		logic [2:0]        corr;
		q_est = CFG_W'(p >> VEL_W) + (CFG_W+1)'(p >> (2*VEL_W))
			+ (CFG_W+1)'(p >> (3*VEL_W));
		rem_w = (PROD_W+1)'(p) - (((PROD_W+1)'(q_est) << VEL_W) - (PROD_W+1)'(q_est));
		rem   = rem_w[9:0];
		corr  = 3'((rem >= 10'(VEL_FULL)) ? 1 : 0) + 3'((rem >= 10'(2*VEL_FULL)) ? 1 : 0)
			+ 3'((rem >= 10'(3*VEL_FULL)) ? 1 : 0) + 3'((rem >= 10'(4*VEL_FULL)) ? 1 : 0);
		return q_est[CFG_W-1:0] + CFG_W'(corr);
	endfunction

endpackage

/* src/pulse_actuator_sequencer.sv */
// ----------------------------------------------------------------------------
// pulse_actuator_sequencer
// One actuator channel: direction pin and PWM duty stepped through idle,
// down and up by tick, velocity, fault and init words.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries command words: tuser holds the command (tick, set
//   velocity and arm, set fault, init), tdata the velocity and fault flag.
//   m_axis returns one status word per command word, showing the channel
//   state after that word was applied.
//   cfg writes down_time, up_time, min_up_time and pwm_max by index; it is
//   always ready, and writes belong in idle periods only.
// Pipeline and throughput:
//   A word is registered on acceptance (together with velocity * pwm_max),
//   then applied to the channel state, whose registers are the status word:
//   m_axis_tvalid rises when the state registers take the word, one word per
//   cycle sustained while m_axis is not stalled. The state step and the
//   divide by 127 are combinational between the input and state registers.
// Reset and stalls:
//   Reset clears the channel to idle with zero outputs and loads the default
//   timings. While m_axis is stalled the status word holds, one more word
//   waits in the input register and s_axis_tready drops.
// ----------------------------------------------------------------------------
`include "pulse_actuator_sequencer_macros.svh"

module pulse_actuator_sequencer
	import pas_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // [6:0] velocity, [7] fault_flag
	input  logic [1:0]        s_axis_tuser,   // [1:0] cmd
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// [0] drive_direction, [16:1] pwm_duty, [18:17] phase, [19] fault_active,
	// [20] armed, [23:21] zero
	output logic [23:0]       m_axis_tdata,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	// configuration
	logic [CFG_W-1:0] down_time_q, up_time_q, min_up_time_q, pwm_max_q;

	// input register
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              fault_flag_s1;

	// channel state, which is also the status word
	logic                  out_valid_q;
	phase_t                phase_q, phase_d;
	logic                  armed_q, armed_d;
	logic                  fault_q, fault_d;
	logic [CFG_W-1:0]      scaled_q, scaled_d;
	logic [TIME_WIDTH-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic                  dir_q, dir_d;
	logic [CFG_W-1:0]      duty_q, duty_d;

	logic advance, proc;

	assign cfg_ready     = 1'b1;
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign proc          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_time_q   <= RST_DOWN_TIME;
			up_time_q     <= RST_UP_TIME;
			min_up_time_q <= RST_MIN_UP_TIME;
			pwm_max_q     <= RST_PWM_MAX;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DOWN_TIME:   down_time_q   <= cfg_data;
				REG_UP_TIME:     up_time_q     <= cfg_data;
				REG_MIN_UP_TIME: min_up_time_q <= cfg_data;
				REG_PWM_MAX:     pwm_max_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload of the input register; product formed ahead of the register
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1        <= cmd_t'(s_axis_tuser);
			prod_s1       <= PROD_W'(s_axis_tdata[VEL_W-1:0]) * PROD_W'(pwm_max_q);
			fault_flag_s1 <= s_axis_tdata[VEL_W];
		end
	end

	assign elapsed_inc = (elapsed_q == TIME_MAX) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		phase_d   = phase_q;
		armed_d   = armed_q;
		fault_d   = fault_q;
		scaled_d  = scaled_q;
		elapsed_d = elapsed_q;
		dir_d     = dir_q;
		duty_d    = duty_q;
		unique case (cmd_s1)
			CMD_TICK: begin
				elapsed_d = elapsed_inc;
				unique case (phase_q)
					PH_IDLE: begin
						if (!fault_q && armed_q) begin
							phase_d = PH_DOWN;
						end
					end
					PH_DOWN: begin
						armed_d = 1'b0;
						if (CMP_W'(elapsed_inc) > CMP_W'(down_time_q)) begin
							phase_d   = PH_UP;
							dir_d     = 1'b0;
							duty_d    = scaled_q;
							elapsed_d = '0;
						end
					end
					PH_UP: begin
						if (CMP_W'(elapsed_inc) >
							CMP_W'(armed_q ? min_up_time_q : up_time_q)) begin
							// leave up: strike again if re-armed, else rest
							phase_d   = armed_q ? PH_DOWN : PH_IDLE;
							dir_d     = armed_q;
							duty_d    = '0;
							elapsed_d = '0;
						end
					end
					default: ;
				endcase
			end
			CMD_VEL: begin
				scaled_d = div_full_scale(prod_s1);
				armed_d  = 1'b1;
			end
			CMD_FAULT: begin
				fault_d = fault_flag_s1;
				if (fault_flag_s1) begin
					dir_d  = 1'b0;
					duty_d = '0;
				end
			end
			CMD_INIT: begin
				phase_d = PH_UP;
				dir_d   = 1'b0;
				duty_d  = scaled_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= PH_IDLE;
			armed_q     <= 1'b0;
			fault_q     <= 1'b0;
			scaled_q    <= '0;
			elapsed_q   <= '0;
			dir_q       <= 1'b0;
			duty_q      <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				phase_q   <= phase_d;
				armed_q   <= armed_d;
				fault_q   <= fault_d;
				scaled_q  <= scaled_d;
				elapsed_q <= elapsed_d;
				dir_q     <= dir_d;
				duty_q    <= duty_d;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, armed_q, fault_q, phase_q, duty_q, dir_q};

	`PAS_ASSERT(a_dir_only_down, clk, arst_n, dir_q |-> (phase_q == PH_DOWN), "direction set outside down")
	`PAS_ASSERT(a_dir_no_duty, clk, arst_n, dir_q |-> (duty_q == '0), "duty driven while pin is down")
	`PAS_ASSERT(a_stall_only, clk, arst_n, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "input held without a stall")
	`PAS_ASSERT(a_down_disarms, clk, arst_n, (proc && cmd_s1 == CMD_TICK && phase_q == PH_DOWN) |=> !armed_q, "tick in down left channel armed")

endmodule

/* sim/tb_pulse_actuator_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_actuator_sequencer
// Self-checking bench for one actuator channel sequencer.
// ----------------------------------------------------------------------------
// A local channel model predicts one status word for every command word that
// the input side accepts. The monitor pops each expectation in order and
// compares it field by field. The run starts with a few hand-made words,
// continues with random command streams under three pacing profiles, with
// timing registers changed between them. One stretch stalls the output side
// for a long time. A final stretch runs with every timing at its maximum.
// ----------------------------------------------------------------------------
module tb_pulse_actuator_sequencer;
	import pas_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED_LO = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_UNUSED_HI = IDX_W'(255);

	typedef struct packed {
		cmd_t       cmd;
		logic [6:0] velocity;
		logic       fault_flag;
	} cmd_word_t;

	typedef struct packed {
		logic             drive_direction;
		logic [CFG_W-1:0] pwm_duty;
		phase_t           phase;
		logic             fault_active;
		logic             armed;
	} chan_status_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata = '0;
	logic [1:0]       s_axis_tuser = CMD_TICK;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [23:0]      m_axis_tdata;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	cmd_word_t    word_q[$];
	chan_status_t status_q[$];
	cmd_word_t    cur_word;
	chan_status_t due;
	int           err_count = 0;
	int           tx_idle_pct = 0;
	int           rx_idle_pct = 0;
	logic         rx_hold = 1'b0;

	// channel model state
	logic [CFG_W-1:0]      ch_down_time, ch_up_time, ch_min_up_time, ch_pwm_max;
	phase_t                ch_phase;
	logic                  ch_armed, ch_fault, ch_dir;
	logic [CFG_W-1:0]      ch_scaled, ch_duty;
	logic [TIME_WIDTH-1:0] ch_elapsed;

	pulse_actuator_sequencer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic void drive_phase(input phase_t ph);
		ch_duty = (ph == PH_UP) ? ch_scaled : '0;
		ch_dir  = (ph == PH_DOWN);
	endfunction

	function automatic chan_status_t apply_word(input cmd_word_t w);
		chan_status_t     st;
		logic [CFG_W-1:0] limit;
		int unsigned      prod;
		case (w.cmd)
			CMD_TICK: begin
				if (ch_elapsed != TIME_MAX)
					ch_elapsed = ch_elapsed + 1'b1;
				case (ch_phase)
					PH_IDLE: begin
						if (!ch_fault && ch_armed)
							ch_phase = PH_DOWN;
					end
					PH_DOWN: begin
						ch_armed = 1'b0;
						if (ch_elapsed > ch_down_time) begin
							drive_phase(PH_UP);
							ch_phase   = PH_UP;
							ch_elapsed = '0;
						end
					end
					default: begin
						limit = ch_armed ? ch_min_up_time : ch_up_time;
						if (ch_elapsed > limit) begin
							ch_phase = ch_armed ? PH_DOWN : PH_IDLE;
							drive_phase(ch_phase);
							ch_elapsed = '0;
						end
					end
				endcase
			end
			CMD_VEL: begin
				prod      = w.velocity * ch_pwm_max;
				ch_scaled = CFG_W'(prod / VEL_FULL);
				ch_armed  = 1'b1;
			end
			CMD_FAULT: begin
				ch_fault = w.fault_flag;
				if (w.fault_flag)
					drive_phase(PH_IDLE);
			end
			default: begin
				drive_phase(PH_UP);
				ch_phase = PH_UP;
			end
		endcase
		st.drive_direction = ch_dir;
		st.pwm_duty        = ch_duty;
		st.phase           = ch_phase;
		st.fault_active    = ch_fault;
		st.armed           = ch_armed;
		return st;
	endfunction

	function automatic cmd_word_t make_word(input cmd_t c, input int vel, input bit flt);
		cmd_word_t w;
		w.cmd        = c;
		w.velocity   = 7'(vel);
		w.fault_flag = flt;
		return w;
	endfunction

	function automatic cmd_word_t random_word();
		cmd_word_t w;
		int        roll;
		roll = $urandom_range(0, 99);
		if (roll < 62)
			w.cmd = CMD_TICK;
		else if (roll < 80)
			w.cmd = CMD_VEL;
		else if (roll < 92)
			w.cmd = CMD_FAULT;
		else
			w.cmd = CMD_INIT;
		case ($urandom_range(0, 9))
			0:       w.velocity = '0;
			1:       w.velocity = 7'(VEL_FULL);
			default: w.velocity = 7'($urandom_range(0, 127));
		endcase
		// keep faults rare enough for strikes to get through
		w.fault_flag = ($urandom_range(0, 99) < 35);
		return w;
	endfunction

	// sender: present words from the pending queue, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= CMD_TICK;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				status_q.push_back(apply_word(cur_word));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (word_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					cur_word = word_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {cur_word.fault_flag, cur_word.velocity};
					s_axis_tuser  <= cur_word.cmd;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each status word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (status_q.size() == 0) begin
					$error("status word with no prediction pending: %h", m_axis_tdata);
					err_count++;
				end else begin
					due = status_q.pop_front();
					if (m_axis_tdata[0] !== due.drive_direction) begin
						$error("drive_direction: expected %0d, got %0d",
							due.drive_direction, m_axis_tdata[0]);
						err_count++;
					end
					if (m_axis_tdata[16:1] !== due.pwm_duty) begin
						$error("pwm_duty: expected %0d, got %0d",
							due.pwm_duty, m_axis_tdata[16:1]);
						err_count++;
					end
					if (m_axis_tdata[18:17] !== due.phase) begin
						$error("phase: expected %0d, got %0d",
							due.phase, m_axis_tdata[18:17]);
						err_count++;
					end
					if (m_axis_tdata[19] !== due.fault_active) begin
						$error("fault_active: expected %0d, got %0d",
							due.fault_active, m_axis_tdata[19]);
						err_count++;
					end
					if (m_axis_tdata[20] !== due.armed) begin
						$error("armed: expected %0d, got %0d",
							due.armed, m_axis_tdata[20]);
						err_count++;
					end
				end
			end
			m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic wait_drained();
		while (word_q.size() != 0 || s_axis_tvalid || status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DOWN_TIME:   ch_down_time   = val;
			REG_UP_TIME:     ch_up_time     = val;
			REG_MIN_UP_TIME: ch_min_up_time = val;
			REG_PWM_MAX:     ch_pwm_max     = val;
			default: ;
		endcase
	endtask

	task automatic set_timing(input int down, input int up, input int min_up, input int pwm);
		wait_drained();
		write_reg(REG_DOWN_TIME, CFG_W'(down));
		write_reg(REG_UP_TIME, CFG_W'(up));
		write_reg(REG_MIN_UP_TIME, CFG_W'(min_up));
		write_reg(REG_PWM_MAX, CFG_W'(pwm));
	endtask

	// random words in bursts; now and then hold off until everything is back
	task automatic run_random(input int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 40);
			repeat (burst) word_q.push_back(random_word());
			count -= burst;
			while (word_q.size() != 0)
				@(posedge clk);
			if ($urandom_range(0, 7) == 0) begin
				wait_drained();
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	initial begin
		ch_down_time   = RST_DOWN_TIME;
		ch_up_time     = RST_UP_TIME;
		ch_min_up_time = RST_MIN_UP_TIME;
		ch_pwm_max     = RST_PWM_MAX;
		ch_phase       = PH_IDLE;
		ch_armed       = 1'b0;
		ch_fault       = 1'b0;
		ch_dir         = 1'b0;
		ch_scaled      = '0;
		ch_duty        = '0;
		ch_elapsed     = '0;
		tx_idle_pct    = 30;
		rx_idle_pct    = 57;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset timings: fault blocks a strike, clearing it lets the strike go
		word_q.push_back(make_word(CMD_TICK, 0, 1'b0));
		word_q.push_back(make_word(CMD_VEL, 127, 1'b1));
		word_q.push_back(make_word(CMD_FAULT, 0, 1'b1));
		word_q.push_back(make_word(CMD_TICK, 127, 1'b1));
		word_q.push_back(make_word(CMD_FAULT, 0, 1'b0));
		word_q.push_back(make_word(CMD_TICK, 0, 1'b0));
		word_q.push_back(make_word(CMD_TICK, 0, 1'b0));
		word_q.push_back(make_word(CMD_INIT, 0, 1'b0));
		word_q.push_back(make_word(CMD_VEL, 0, 1'b0));
		word_q.push_back(make_word(CMD_INIT, 127, 1'b1));

		// zero timings and zero full scale; writes to unknown indexes go nowhere
		set_timing(0, 0, 0, 0);
		write_reg(REG_UNUSED_LO, 16'hFFFF);
		write_reg(REG_UNUSED_HI, 16'h0001);
		word_q.push_back(make_word(CMD_VEL, 127, 1'b0));
		repeat (3) word_q.push_back(make_word(CMD_TICK, 0, 1'b0));
		word_q.push_back(make_word(CMD_FAULT, 0, 1'b1));
		word_q.push_back(make_word(CMD_TICK, 0, 1'b0));
		word_q.push_back(make_word(CMD_FAULT, 0, 1'b0));
		word_q.push_back(make_word(CMD_VEL, 64, 1'b0));
		repeat (4) word_q.push_back(make_word(CMD_TICK, 0, 1'b0));

		set_timing($urandom_range(0, 6), $urandom_range(0, 10), $urandom_range(0, 4), 65535);
		run_random(320);

		tx_idle_pct = 57;
		rx_idle_pct = 30;
		set_timing($urandom_range(0, 20), $urandom_range(0, 30), $urandom_range(0, 10),
			$urandom_range(1, 65535));
		run_random(320);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_timing(1, 2, 1, 1);
		// stall the output side while words keep coming, so the input backs up
		repeat (60) word_q.push_back(random_word());
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
		run_random(280);

		// maximal timings: no tick ever leaves down or up
		set_timing(65535, 65535, 65535, 127);
		word_q.push_back(make_word(CMD_FAULT, 0, 1'b0));
		word_q.push_back(make_word(CMD_VEL, 100, 1'b0));
		repeat (6) word_q.push_back(make_word(CMD_TICK, 0, 1'b0));
		word_q.push_back(make_word(CMD_INIT, 0, 1'b0));
		repeat (4) word_q.push_back(make_word(CMD_TICK, 0, 1'b0));

		wait_drained();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
